// ===== design/pfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfcd_pkg
// Types, codes and constants shared by the camera-control frame decoder.
// ----------------------------------------------------------------------------
package pfcd_pkg;

    // Scene wheel size; scenes numbered 4 and up are never selectable.
    localparam int SCENE_COUNT = 4;

    // Frame headers and the alternate-format marker in byte 6.
    localparam logic [7:0] HDR_STD  = 8'hFF;
    localparam logic [7:0] HDR_ALT  = 8'hA0;
    localparam logic [7:0] ALT_MARK = 8'hAF;

    // Frame byte positions.
    localparam logic [3:0] POS_HDR  = 4'd0;
    localparam logic [3:0] POS_ADDR = 4'd1;
    localparam logic [3:0] POS_CMD1 = 4'd2;
    localparam logic [3:0] POS_CMD2 = 4'd3;
    localparam logic [3:0] POS_SUM5 = 4'd5;
    localparam logic [3:0] POS_B6   = 4'd6;
    localparam logic [3:0] POS_B7   = 4'd7;
    localparam logic [3:0] POS_SAT  = 4'd8;

    // Command codes on the result channel.
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_ZOOM_IN   = 4'd1;
    localparam logic [3:0] CMD_ZOOM_OUT  = 4'd2;
    localparam logic [3:0] CMD_FOCUS_ADD = 4'd3;
    localparam logic [3:0] CMD_FOCUS_SUB = 4'd4;
    localparam logic [3:0] CMD_POWER_OFF = 4'd5;
    localparam logic [3:0] CMD_POWER_ON  = 4'd6;
    localparam logic [3:0] CMD_SCENE     = 4'd7;
    localparam logic [3:0] CMD_STOP      = 4'd8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
    localparam logic [1:0] CFG_SCENE_MASK = 2'd1;
    localparam logic [1:0] CFG_FOCUS_MAN  = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] RST_DEV_ADDR   = 8'd1;
    localparam logic [3:0] RST_SCENE_MASK = 4'hF;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [3:0] command;
        logic [1:0] scene_select;
        logic       power_state;
        logic       af_trigger;
    } t_out_item;

    // Captured frame fields plus running checksum.
    typedef struct packed {
        logic [7:0] header;
        logic [7:0] address;
        logic [7:0] cmd_high;
        logic [7:0] cmd_low;
        logic [7:0] sum;
        logic [7:0] byte6;
        logic [7:0] byte7;
    } t_frame;

    // Configuration as seen by the decode stage.
    typedef struct packed {
        logic [7:0] dev_addr;
        logic [3:0] scene_mask;
        logic       focus_manual;
    } t_cfg;

endpackage

// ===== design/pelco_frame_command_decoder_top.sv =====
// ----------------------------------------------------------------------------
// pelco_frame_command_decoder_top
// Camera-control frame decoder: bytes in, one command item per frame out.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle (0xFF header with checksum in byte 6, or
// 0xA0 header with 0xAF in byte 6 and checksum in byte 7; checksum is the
// 8-bit sum of bytes 1..5) and emits one result item per end-of-frame byte,
// registered in the completed-frame register and then the result register.
// Throughput is one byte per cycle: the byte assembler, a completed-frame
// register and the result register each move an item every cycle, and input
// ready drops only while the result register is held by output backpressure.
// Invalid frames give command none with scene and power unchanged. Config
// writes are always taken and must be issued only while the block is idle.
// ----------------------------------------------------------------------------
module pelco_frame_command_decoder_top
    import pfcd_pkg::*;
#(
    parameter int P_SCENE_COUNT = SCENE_COUNT
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg   r_cfg;
    logic   w_frame_vld;
    t_frame w_frame;
    logic   w_frame_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr     <= RST_DEV_ADDR;
            r_cfg.scene_mask   <= RST_SCENE_MASK;
            r_cfg.focus_manual <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEV_ADDR:   r_cfg.dev_addr     <= i_cfg_data;
                CFG_SCENE_MASK: r_cfg.scene_mask   <= i_cfg_data[3:0];
                CFG_FOCUS_MAN:  r_cfg.focus_manual <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    pfcd_assembler u_assembler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_frame_vld  (w_frame_vld),
        .o_frame      (w_frame),
        .i_frame_take (w_frame_take)
    );

    pfcd_decoder #(
        .P_SCENE_COUNT (P_SCENE_COUNT)
    ) u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_frame_vld  (w_frame_vld),
        .i_frame      (w_frame),
        .o_frame_take (w_frame_take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== design/pfcd_assembler.sv =====
// ----------------------------------------------------------------------------
// pfcd_assembler
// Captures frame bytes by position, keeps the running checksum and hands the
// completed frame to the decode stage on the end-of-frame byte.
// ----------------------------------------------------------------------------
module pfcd_assembler
    import pfcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_frame_vld,
    output t_frame   o_frame,
    input  logic     i_frame_take
);

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    t_frame     r_acc;
    t_frame     n_acc;
    t_frame     r_frame;
    logic       r_frame_vld;
    logic       w_accept;
    logic [7:0] w_b;

    assign w_b        = i_in_data.rx_byte;
    // Frame slot free, or being drained this cycle.
    assign o_in_ready = !r_frame_vld || i_frame_take;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_acc = r_acc;
        case (r_pos)
            POS_HDR:  n_acc.header   = w_b;
            POS_ADDR: n_acc.address  = w_b;
            POS_CMD1: n_acc.cmd_high = w_b;
            POS_CMD2: n_acc.cmd_low  = w_b;
            POS_B6:   n_acc.byte6    = w_b;
            POS_B7:   n_acc.byte7    = w_b;
            default:  ;
        endcase
        if (r_pos >= POS_ADDR && r_pos <= POS_SUM5) begin
            n_acc.sum = r_acc.sum + w_b;
        end
        n_pos = (r_pos < POS_SAT) ? r_pos + 4'd1 : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_acc       <= '0;
            r_frame_vld <= 1'b0;
        end else begin
            if (i_frame_take) begin
                r_frame_vld <= 1'b0;
            end
            if (w_accept) begin
                if (i_in_data.frame_end) begin
                    r_pos       <= '0;
                    r_acc       <= '0;
                    r_frame_vld <= 1'b1;
                end else begin
                    r_pos <= n_pos;
                    r_acc <= n_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.frame_end) begin
            r_frame <= n_acc;
        end
    end

    assign o_frame_vld = r_frame_vld;
    assign o_frame     = r_frame;

endmodule

// ===== design/pfcd_decoder.sv =====
// ----------------------------------------------------------------------------
// pfcd_decoder
// Validates a completed frame, maps the command bytes to a command, updates
// the power flag and scene index, and holds the result for the output side.
// ----------------------------------------------------------------------------
module pfcd_decoder
    import pfcd_pkg::*;
#(
    parameter int P_SCENE_COUNT = SCENE_COUNT
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_frame_vld,
    input  t_frame    i_frame,
    output logic      o_frame_take,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Scenes past 3 are never defined, so the search wraps within this span.
    localparam int SCENE_SPAN = (P_SCENE_COUNT < 4) ? P_SCENE_COUNT : 4;
    localparam logic [1:0] SCENE_LAST = 2'(SCENE_SPAN - 1);

    localparam logic [7:0] LO_ZOOM_IN  = 8'h20;
    localparam logic [7:0] LO_ZOOM_OUT = 8'h40;
    localparam logic [7:0] LO_FOCUS_ST = 8'h80;
    localparam logic [7:0] LO_SCENE    = 8'h01;
    localparam logic [7:0] HI_FOCUS_ST = 8'h01;
    localparam logic [7:0] HI_POWER_ST = 8'h08;
    localparam logic [7:0] HI_FADD_ALT = 8'h01;
    localparam logic [7:0] HI_FSUB_ALT = 8'h02;
    localparam logic [7:0] HI_POWER_AL = 8'h10;

    logic       r_power;
    logic [1:0] r_scene;
    logic       r_out_vld;
    t_out_item  r_out;

    logic       w_valid;
    logic       w_alt;
    logic       w_is_power;
    logic [3:0] w_cmd;
    logic [3:0] n_cmd;
    logic       n_power;
    logic [1:0] n_scene;
    logic       n_trig;
    logic       w_found;
    logic [1:0] w_cand;
    logic [1:0] w_pick;

    assign o_frame_take = i_frame_vld && (!r_out_vld || i_out_ready);

    always_comb begin
        w_valid = 1'b0;
        w_alt   = 1'b0;
        if (i_frame.address == i_cfg.dev_addr) begin
            if (i_frame.header == HDR_STD) begin
                w_valid = (i_frame.sum == i_frame.byte6);
            end else if (i_frame.header == HDR_ALT && i_frame.byte6 == ALT_MARK) begin
                w_alt   = 1'b1;
                w_valid = (i_frame.sum == i_frame.byte7);
            end
        end
    end

    // Command byte pair to code; power is flagged and resolved below.
    always_comb begin
        logic [7:0] hi;
        logic [7:0] lo;
        hi         = i_frame.cmd_high;
        lo         = i_frame.cmd_low;
        w_cmd      = CMD_NONE;
        w_is_power = 1'b0;
        if (hi == 8'h00 && lo == LO_ZOOM_IN) begin
            w_cmd = CMD_ZOOM_IN;
        end else if (hi == 8'h00 && lo == LO_ZOOM_OUT) begin
            w_cmd = CMD_ZOOM_OUT;
        end else if (!w_alt && hi == 8'h00 && lo == LO_FOCUS_ST) begin
            w_cmd = CMD_FOCUS_ADD;
        end else if (!w_alt && hi == HI_FOCUS_ST && lo == 8'h00) begin
            w_cmd = CMD_FOCUS_SUB;
        end else if (!w_alt && hi == HI_POWER_ST && lo == 8'h00) begin
            w_is_power = 1'b1;
        end else if (w_alt && hi == HI_FADD_ALT && lo == 8'h00) begin
            w_cmd = CMD_FOCUS_ADD;
        end else if (w_alt && hi == HI_FSUB_ALT && lo == 8'h00) begin
            w_cmd = CMD_FOCUS_SUB;
        end else if (w_alt && hi == HI_POWER_AL && lo == 8'h00) begin
            w_is_power = 1'b1;
        end else if (hi == 8'h00 && lo == LO_SCENE) begin
            w_cmd = CMD_SCENE;
        end else if (hi == 8'h00 && lo == 8'h00) begin
            w_cmd = CMD_STOP;
        end
    end

    // Next defined scene after the current one, wrapping.
    always_comb begin
        w_found = 1'b0;
        w_pick  = r_scene;
        w_cand  = r_scene;
        for (int k = 0; k < SCENE_SPAN; k++) begin
            w_cand = (w_cand == SCENE_LAST) ? 2'd0 : w_cand + 2'd1;
            if (!w_found && i_cfg.scene_mask[w_cand]) begin
                w_found = 1'b1;
                w_pick  = w_cand;
            end
        end
    end

    always_comb begin
        n_cmd   = CMD_NONE;
        n_power = r_power;
        n_scene = r_scene;
        n_trig  = 1'b0;
        if (w_valid) begin
            if (w_is_power) begin
                n_power = !r_power;
                n_cmd   = r_power ? CMD_POWER_OFF : CMD_POWER_ON;
            end else if (w_cmd == CMD_SCENE) begin
                if (w_found) begin
                    n_scene = w_pick;
                    n_cmd   = CMD_SCENE;
                end
            end else begin
                n_cmd  = w_cmd;
                n_trig = (w_cmd == CMD_STOP) && i_cfg.focus_manual;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power   <= 1'b1;
            r_scene   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_frame_take) begin
                r_power   <= n_power;
                r_scene   <= n_scene;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_frame_take) begin
            r_out.command      <= n_cmd;
            r_out.scene_select <= n_scene;
            r_out.power_state  <= n_power;
            r_out.af_trigger   <= n_trig;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
